// ===== rtl/gelu_polynomial_activation_unit_defines.svh =====
// Assertion macros shared by the GELU activation unit.
`ifndef GELU_POLYNOMIAL_ACTIVATION_UNIT_DEFINES_SVH
`define GELU_POLYNOMIAL_ACTIVATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gelu activation unit check failed");

// Next-cycle implication, disabled while reset is held.
`define GPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gelu activation unit check failed");

`endif

// ===== rtl/gpa_pkg.sv =====
// Shared types and constants of the GELU activation unit.
package gpa_pkg;

    localparam int DataW  = 16;
    localparam int MagW   = 13;  // clamped magnitude, 0..5120
    localparam int PosW   = 15;  // positive part, 0..32767
    localparam int AccW   = 32;  // Horner accumulator, Q.20
    localparam int Terms  = 6;

    localparam logic [MagW-1:0] ClampQ10 = 13'd5120;

    // Fit coefficients in Q.20, highest order first.
    localparam logic signed [AccW-1:0] PolyQ20 [0:Terms-1] = '{
        32'sd2974, -32'sd45362, 32'sd256617, -32'sd639046, 32'sd593907, -32'sd4733
    };

    typedef struct packed {
        logic                   valid;
        logic [MagW-1:0]        a;
        logic [PosW-1:0]        s;
        logic signed [AccW-1:0] p;
    } t_pipe;

endpackage

// ===== rtl/gelu_polynomial_activation_unit.sv =====
// GELU activation unit: front stage, five Horner stages, output stage.
// Each accepted sample passes the front, Horner and output registers before o_valid rises.
// Throughput: one item per cycle; busy never rises since nothing stalls.
// The depth is set by the front stage, the five registered Horner multiply-add steps and the output stage.
// Synchronous active-low reset clears all valid bits; items in flight are dropped.
`include "gelu_polynomial_activation_unit_defines.svh"

module gelu_polynomial_activation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gpa_pkg::DataW-1:0]    i_x_in,
    output logic                                o_valid,
    output logic signed [gpa_pkg::DataW-1:0]    o_y_out
);

    gpa_pkg::t_pipe w_pipe [0:gpa_pkg::Terms-1];
    logic           w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    gpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_x     (i_x_in),
        .o_stage (w_pipe[0])
    );

    for (genvar k = 1; k < gpa_pkg::Terms; k++) begin : g_horner
        gpa_horner_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_pipe[k-1]),
            .i_coef  (gpa_pkg::PolyQ20[k]),
            .o_stage (w_pipe[k])
        );
    end

    gpa_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_pipe[gpa_pkg::Terms-1]),
        .o_valid (o_valid),
        .o_y     (o_y_out)
    );

    `GPA_ASSERT_IMPL(a_item_emerges, w_accept, ##7 o_valid)
    `GPA_ASSERT_IMPL(a_no_invented_result, o_valid, $past(w_accept, 7))
    `GPA_ASSERT_NEXT(a_neg_not_positive,
        w_pipe[gpa_pkg::Terms-1].valid && w_pipe[gpa_pkg::Terms-1].s == '0
            && w_pipe[gpa_pkg::Terms-1].p >= 0,
        o_y_out <= 0)

endmodule

// ===== rtl/gpa_front.sv =====
// Input stage: clamped magnitude and positive part of the sample.
`include "gelu_polynomial_activation_unit_defines.svh"

module gpa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [gpa_pkg::DataW-1:0]    i_x,
    output gpa_pkg::t_pipe                      o_stage
);

    logic [gpa_pkg::DataW:0] w_ax;
    gpa_pkg::t_pipe          r_q;
    gpa_pkg::t_pipe          n_q;

    // widened so the most negative sample has a magnitude
    assign w_ax = i_x[gpa_pkg::DataW-1] ? (17'd0 - {i_x[gpa_pkg::DataW-1], i_x})
                                        : {1'b0, i_x};

    always_comb begin
        n_q.valid = i_valid;
        n_q.a     = (w_ax > 17'(gpa_pkg::ClampQ10)) ? gpa_pkg::ClampQ10
                                                    : w_ax[gpa_pkg::MagW-1:0];
        n_q.s     = i_x[gpa_pkg::DataW-1] ? '0 : i_x[gpa_pkg::PosW-1:0];
        n_q.p     = gpa_pkg::PolyQ20[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
        r_q.a <= n_q.a;
        r_q.s <= n_q.s;
        r_q.p <= n_q.p;
    end

    assign o_stage = r_q;

    `GPA_ASSERT_IMPL(a_mag_clamped, r_q.valid, r_q.a <= gpa_pkg::ClampQ10)
    `GPA_ASSERT_IMPL(a_pos_within_mag,
        r_q.valid && r_q.s != '0 && r_q.s <= 15'(gpa_pkg::ClampQ10),
        r_q.a == r_q.s[gpa_pkg::MagW-1:0])

endmodule

// ===== rtl/gpa_horner_stage.sv =====
// One Horner step: p = round(p * a / 2^10) + c.
module gpa_horner_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gpa_pkg::t_pipe                      i_stage,
    input  logic signed [gpa_pkg::AccW-1:0]     i_coef,
    output gpa_pkg::t_pipe                      o_stage
);

    localparam int ProdW = gpa_pkg::AccW + gpa_pkg::MagW + 1;

    logic signed [ProdW-1:0] w_prod;
    logic signed [ProdW-1:0] w_rnd;
    gpa_pkg::t_pipe          r_q;
    gpa_pkg::t_pipe          n_q;

    assign w_prod = i_stage.p * $signed({1'b0, i_stage.a});
    // floor((v + 512) / 1024): round to nearest, ties up
    assign w_rnd  = (w_prod + ProdW'(512)) >>> 10;

    always_comb begin
        n_q       = i_stage;
        n_q.p     = $signed(w_rnd[gpa_pkg::AccW-1:0]) + i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
        r_q.a <= n_q.a;
        r_q.s <= n_q.s;
        r_q.p <= n_q.p;
    end

    assign o_stage = r_q;

endmodule

// ===== rtl/gpa_out.sv =====
// Output stage: y = round(s - p), saturated to 16 bits.
module gpa_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gpa_pkg::t_pipe                      i_stage,
    output logic                                o_valid,
    output logic signed [gpa_pkg::DataW-1:0]    o_y
);

    localparam int DiffW = gpa_pkg::AccW + 2;

    logic signed [DiffW-1:0]         w_diff;
    logic signed [DiffW-1:0]         w_rnd;
    logic                            r_valid;
    logic signed [gpa_pkg::DataW-1:0] r_y;
    logic signed [gpa_pkg::DataW-1:0] n_y;

    assign w_diff = $signed({9'd0, i_stage.s, 10'd0})
                  - $signed({{2{i_stage.p[gpa_pkg::AccW-1]}}, i_stage.p});
    assign w_rnd  = (w_diff + DiffW'(512)) >>> 10;

    always_comb begin
        if (w_rnd > DiffW'(32767)) begin
            n_y = 16'sh7fff;
        end else if (w_rnd < -DiffW'(32768)) begin
            n_y = 16'sh8000;
        end else begin
            n_y = w_rnd[gpa_pkg::DataW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
        r_y <= n_y;
    end

    assign o_valid = r_valid;
    assign o_y     = r_y;

endmodule

// ===== verif/tb_gelu_polynomial_activation_unit.sv =====
// Self-checking testbench of the GELU activation unit: directed and random samples.
module tb_gelu_polynomial_activation_unit;

    localparam int W         = gpa_pkg::DataW;
    localparam int DRAIN_CYC = 20;      // pipeline is 7 deep
    localparam int MAX_CYC   = 200000;
    localparam int MAX_SHOWN = 10;
    localparam int RAND_N    = 600;     // items per random test

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic signed [W-1:0] i_x_in = '0;
    logic                busy;
    logic                o_valid;
    logic signed [W-1:0] o_y_out;

    // expected outputs, oldest first, with the sample that caused each
    logic signed [W-1:0] gelu_want_q[$];
    logic signed [W-1:0] gelu_src_q[$];

    int n_sent     = 0;
    int n_checked  = 0;
    int n_mismatch = 0;
    int cycle_cnt  = 0;

    gelu_polynomial_activation_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_x_in  (i_x_in),
        .o_valid (o_valid),
        .o_y_out (o_y_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYC) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, gelu_want_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Fit coefficients in Q.20, highest order first.
    function automatic longint fit_coef(input int k);
        case (k)
            0: fit_coef = 2974;
            1: fit_coef = -45362;
            2: fit_coef = 256617;
            3: fit_coef = -639046;
            4: fit_coef = 593907;
            default: fit_coef = -4733;
        endcase
    endfunction

    function automatic logic signed [W-1:0] gelu_q10(input logic signed [W-1:0] x);
        longint xv;
        longint mag;
        longint a;
        longint pos;
        longint p;
        longint y;
        xv  = x;
        mag = (xv < 0) ? -xv : xv;
        a   = (mag > 5120) ? 5120 : mag;
        pos = (xv > 0) ? xv : 0;
        p   = fit_coef(0);
        // >>> on a signed longint floors, so +512 then shift rounds half up
        for (int k = 1; k < 6; k++)
            p = ((p * a + 512) >>> 10) + fit_coef(k);
        y = (pos * 1024 - p + 512) >>> 10;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        gelu_q10 = y[W-1:0];
    endfunction

    // Called just after the clock rises; returns as soon as the unit has taken the item.
    task automatic drive_sample(input logic signed [W-1:0] x);
        start  <= 1'b1;
        i_x_in <= x;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        gelu_want_q.push_back(gelu_q10(x));
        gelu_src_q.push_back(x);
        n_sent++;
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start  <= 1'b0;
            i_x_in <= W'($urandom());
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [W-1:0] pick_sample();
        int r;
        int v;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom();
        if (r < 55)
            v = int'($urandom_range(0, 12000)) - 6000;     // where the polynomial bends
        else if (r < 70)
            v = (raw[0] ? 5120 : -5120) + int'($urandom_range(0, 8)) - 4;  // clamp edge
        else
            v = int'(raw[W-1:0]) - 32768;                  // full range
        pick_sample = v[W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (gelu_want_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_SHOWN)
                    $display("unexpected result y=%0d at cycle %0d", o_y_out, cycle_cnt);
            end else begin
                if (o_y_out !== gelu_want_q[0]) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN)
                        $display("y mismatch: x=%0d expected %0d got %0d",
                                 gelu_src_q[0], gelu_want_q[0], o_y_out);
                end
                void'(gelu_want_q.pop_front());
                void'(gelu_src_q.pop_front());
                n_checked++;
            end
        end
    end

    task automatic test_directed();
        logic signed [W-1:0] pts[$];
        pts = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                16'sh0400, -16'sh0400, 16'sh1400, -16'sh1400, 16'sh13ff,
                -16'sh13ff, 16'sh1401, -16'sh1401, 16'sh0200, -16'sh0200,
                16'sh7c00, 16'sh8001, 16'sh5555, 16'shaaaa, 16'sh0a00,
                -16'sh0a00, 16'sh7ffe};
        foreach (pts[i])
            drive_sample(pts[i]);
    endtask

    task automatic run_random(input int gap_pct);
        for (int i = 0; i < RAND_N; i++) begin
            sender_gap(gap_pct);
            drive_sample(pick_sample());
        end
    endtask

    task automatic test_random_sparse_sender();
        run_random(35);
    endtask

    task automatic test_random_slow_sender();
        run_random(79);
    endtask

    task automatic test_random_back_to_back();
        run_random(0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sparse_sender();
        test_random_slow_sender();
        test_random_back_to_back();
        start <= 1'b0;

        while (gelu_want_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("sent %0d samples (directed edges, clamp boundary, full range)", n_sent);
        $display("checked %0d results, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0 && gelu_want_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
